// ----- sv/mpl_pkg.sv -----
package mpl_pkg;

  localparam int COORD_W = 24;
  localparam int IDX_W   = 12;
  localparam int TOL_W   = 52;
  localparam int CNT_W   = 13;
  localparam int PROD_W  = 52;

  typedef enum logic [1:0] {
    REQ_NODE   = 2'd0,
    REQ_ELEM   = 2'd1,
    REQ_LOCATE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  localparam logic [0:0] REG_TOL = 1'b0;
  localparam logic [0:0] REG_CNT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_query;   // capture query point, clear scan
    logic fetch_elem;   // read element entry at scan index
    logic fetch_node;   // read corner node (corner select below)
    logic [1:0] corner;
    logic calc_edge;    // multiply for edge of corner sel
    logic sum_edge;     // add and compare
    logic next_elem;    // advance scan index
    logic hit;          // record found
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;    // index reached count
    logic is_quad;
    logic edge_fail;
  } dp_sts_t;

endpackage

// ----- sv/mpl_if.sv -----
interface mpl_in_if;
  import mpl_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic [IDX_W-1:0] entry_index;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic [IDX_W-1:0] node_a;
  logic [IDX_W-1:0] node_b;
  logic [IDX_W-1:0] node_c;
  logic [IDX_W-1:0] node_d;
  logic is_quad;
  modport source (output valid, req_type, entry_index, x_coord, y_coord,
                  node_a, node_b, node_c, node_d, is_quad, input ready);
  modport sink (input valid, req_type, entry_index, x_coord, y_coord,
                node_a, node_b, node_c, node_d, is_quad, output ready);
endinterface

interface mpl_out_if;
  import mpl_pkg::*;
  logic valid;
  logic ready;
  logic found;
  logic [IDX_W-1:0] elem_index;
  modport source (output valid, found, elem_index, input ready);
  modport sink (input valid, found, elem_index, output ready);
endinterface

// ----- sv/mpl_datapath.sv -----
module mpl_datapath
  import mpl_pkg::*;
#(
  parameter int MAX_NODES = 4096,
  parameter int MAX_ELEMS = 4096
) (
  input  logic clk,
  input  dp_cmd_t cmd,
  output dp_sts_t sts,
  // load ports
  input  logic node_we,
  input  logic elem_we,
  input  logic [IDX_W-1:0] wr_index,
  input  logic signed [COORD_W-1:0] wr_x,
  input  logic signed [COORD_W-1:0] wr_y,
  input  logic [4*IDX_W:0] wr_elem,
  input  logic signed [COORD_W-1:0] q_x,
  input  logic signed [COORD_W-1:0] q_y,
  input  logic signed [TOL_W-1:0] tol,
  input  logic [CNT_W-1:0] elem_count,
  output logic [IDX_W-1:0] hit_index
);
  localparam int NA_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EA_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int SC_W = $clog2(MAX_ELEMS + 1);
  localparam int D_W  = COORD_W + 1;

  logic signed [COORD_W-1:0] node_x_mem [MAX_NODES];
  logic signed [COORD_W-1:0] node_y_mem [MAX_NODES];
  logic [4*IDX_W:0] elem_mem [MAX_ELEMS];

  logic [4*IDX_W:0] elem_r;
  logic signed [COORD_W-1:0] nx_r, ny_r;
  logic nvalid_r;
  logic signed [COORD_W-1:0] cx_r [4];
  logic signed [COORD_W-1:0] cy_r [4];
  logic signed [COORD_W-1:0] px_r, py_r;
  logic [SC_W-1:0] scan_r;
  logic signed [PROD_W-1:0] p0_r, p1_r;
  logic fail_r;
  logic [IDX_W-1:0] hit_r;

  // clamp count
  logic [SC_W-1:0] lim;
  always_comb begin
    if ({19'd0, elem_count} > 32'(MAX_ELEMS)) lim = SC_W'(MAX_ELEMS);
    else lim = SC_W'(elem_count);
  end

  always_ff @(posedge clk) begin
    if (node_we && ({20'd0, wr_index} < 32'(MAX_NODES))) begin
      node_x_mem[NA_W'(wr_index)] <= wr_x;
      node_y_mem[NA_W'(wr_index)] <= wr_y;
    end
    if (elem_we && ({20'd0, wr_index} < 32'(MAX_ELEMS)))
      elem_mem[EA_W'(wr_index)] <= wr_elem;
    if (cmd.fetch_elem) elem_r <= elem_mem[EA_W'(scan_r)];
  end

  // corner index select and node read
  logic [IDX_W-1:0] cidx;
  always_comb begin
    case (cmd.corner)
      2'd0: cidx = elem_r[IDX_W-1:0];
      2'd1: cidx = elem_r[2*IDX_W-1:IDX_W];
      2'd2: cidx = elem_r[3*IDX_W-1:2*IDX_W];
      default: cidx = elem_r[4*IDX_W-1:3*IDX_W];
    endcase
  end

  logic [1:0] cor_r;
  always_ff @(posedge clk) begin
    if (cmd.fetch_node) begin
      nx_r <= node_x_mem[NA_W'(cidx)];
      ny_r <= node_y_mem[NA_W'(cidx)];
      nvalid_r <= ({20'd0, cidx} < 32'(MAX_NODES));
      cor_r <= cmd.corner;
    end
  end

  // corner registers, written in the cycle after the node read
  logic wr_corner_r;
  always_ff @(posedge clk) begin
    wr_corner_r <= cmd.fetch_node;
    if (wr_corner_r) begin
      cx_r[cor_r] <= nvalid_r ? nx_r : '0;
      cy_r[cor_r] <= nvalid_r ? ny_r : '0;
    end
  end

  // edge of corner i to corner j
  logic [1:0] ci, cj;
  logic signed [D_W-1:0] d0, d1, d2, d3;
  always_comb begin
    ci = cmd.corner;
    if (elem_r[4*IDX_W] ? (ci == 2'd3) : (ci == 2'd2)) cj = 2'd0;
    else cj = ci + 2'd1;
    d0 = D_W'(px_r) - D_W'(cx_r[ci]);
    d1 = D_W'(cy_r[ci]) - D_W'(cy_r[cj]);
    d2 = D_W'(py_r) - D_W'(cy_r[ci]);
    d3 = D_W'(cx_r[cj]) - D_W'(cx_r[ci]);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      px_r <= q_x;
      py_r <= q_y;
      scan_r <= '0;
      fail_r <= 1'b0;
      hit_r <= '0;
    end else begin
      if (cmd.calc_edge) begin
        p0_r <= PROD_W'(d0 * d1);
        p1_r <= PROD_W'(d2 * d3);
      end
      if (cmd.sum_edge && ((p0_r + p1_r) < tol)) fail_r <= 1'b1;
      if (cmd.next_elem) begin
        scan_r <= scan_r + 1'b1;
        fail_r <= 1'b0;
      end
      if (cmd.hit) hit_r <= IDX_W'(scan_r);
    end
  end

  assign sts.scan_done = (scan_r >= lim);
  assign sts.is_quad = elem_r[4*IDX_W];
  assign sts.edge_fail = fail_r;
  assign hit_index = hit_r;
endmodule

// ----- sv/mpl_ctrl.sv -----
module mpl_ctrl
  import mpl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic busy,
  output logic done,
  output logic found
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_ELEM  = 8'b0000_0100,
    S_NODE  = 8'b0000_1000,
    S_SETL  = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_EVAL  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic found_r, found_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      found_r <= found_nxt;
    end
  end

  logic [2:0] ncorn;
  assign ncorn = sts.is_quad ? 3'd4 : 3'd3;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    found_nxt = found_r;
    cmd = '0;
    done = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_query = 1'b1;
          found_nxt = 1'b0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.scan_done) begin
          done = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.fetch_elem = 1'b1;
          state_nxt = S_ELEM;
        end
      end
      S_ELEM: begin
        cnt_nxt = '0;
        state_nxt = S_NODE;
      end
      S_NODE: begin
        cmd.fetch_node = 1'b1;
        cmd.corner = cnt_r[1:0];
        if (cnt_r + 3'd1 == ncorn) begin
          cnt_nxt = '0;
          state_nxt = S_SETL;
        end else cnt_nxt = cnt_r + 3'd1;
      end
      S_SETL: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.calc_edge = 1'b1;
        cmd.corner = cnt_r[1:0];
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum_edge = 1'b1;
        if (cnt_r + 3'd1 == ncorn) state_nxt = S_EVAL;
        else begin
          cnt_nxt = cnt_r + 3'd1;
          state_nxt = S_MUL;
        end
      end
      S_EVAL: begin
        if (!sts.edge_fail) begin
          cmd.hit = 1'b1;
          found_nxt = 1'b1;
          done = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.next_elem = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign found = found_nxt;
endmodule

// ----- sv/mesh_point_locator_top.sv -----
// channel | dir | payload                                      | handshake
// in_     | in  | req_type entry_index x y node_a..d is_quad  | valid/ready
// out_    | out | found elem_index                             | valid/ready
// cfg_    | in  | tolerance (0x0), element_count (0x8)         | apb, pready=1
// loads and idle selectors post a result word in the cycle after they are taken
// per element a locate steps through the count check, element read, one read per corner,
// corner settle, a multiply and a sum step per edge, and the verdict
// a new word is taken only when no search runs and no result word waits or is posting
// rst_n is synchronous; mesh stores are not cleared and hold garbage until loaded
// the output register holds its word while out_ready is low
module mesh_point_locator_top
  import mpl_pkg::*;
#(
  parameter int MAX_NODES = 4096,
  parameter int MAX_ELEMS = 4096
) (
  input  logic clk,
  input  logic rst_n,
  mpl_in_if.sink in_ch,
  mpl_out_if.source out_ch,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [3:0] cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic cfg_pready
);
  // config registers
  logic signed [TOL_W-1:0] tol_r;
  logic [CNT_W-1:0] count_r;
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
      count_r <= '0;
    end else if (cfg_wr && cfg_paddr[2:0] == 3'd0) begin
      unique case (cfg_paddr[3])
        REG_TOL: tol_r <= cfg_pwdata[TOL_W-1:0];
        REG_CNT: count_r <= cfg_pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2:0] == 3'd0) begin
      unique case (cfg_paddr[3])
        REG_TOL: cfg_prdata = {{(64-TOL_W){tol_r[TOL_W-1]}}, tol_r};
        REG_CNT: cfg_prdata = {{(64-CNT_W){1'b0}}, count_r};
        default: ;
      endcase
    end
  end

  // input acceptance
  logic busy, done, found, out_v_r, take;
  logic pend_r;
  logic out_found_r;
  logic [IDX_W-1:0] out_idx_r, hit_index;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign in_ch.ready = !busy && !out_v_r && !pend_r;
  assign take = in_ch.valid && in_ch.ready;

  logic is_loc, node_we, elem_we;
  assign is_loc  = take && (in_ch.req_type == REQ_LOCATE);
  assign node_we = take && (in_ch.req_type == REQ_NODE);
  assign elem_we = take && (in_ch.req_type == REQ_ELEM);

  mpl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(is_loc), .sts(sts), .cmd(cmd),
    .busy(busy), .done(done), .found(found)
  );

  mpl_datapath #(.MAX_NODES(MAX_NODES), .MAX_ELEMS(MAX_ELEMS)) u_dp (
    .clk(clk), .cmd(cmd), .sts(sts),
    .node_we(node_we), .elem_we(elem_we), .wr_index(in_ch.entry_index),
    .wr_x(in_ch.x_coord), .wr_y(in_ch.y_coord),
    .wr_elem({in_ch.is_quad, in_ch.node_d, in_ch.node_c, in_ch.node_b, in_ch.node_a}),
    .q_x(in_ch.x_coord), .q_y(in_ch.y_coord), .tol(tol_r), .elem_count(count_r),
    .hit_index(hit_index)
  );

  // hit index is registered in the same edge as done; take scan index one way
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= done;
      if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      if (take && !is_loc) begin
        out_v_r <= 1'b1;
        out_found_r <= 1'b0;
        out_idx_r <= '0;
      end
      if (done) out_found_r <= found;
      if (pend_r) begin
        out_v_r <= 1'b1;
        out_idx_r <= out_found_r ? hit_index : '0;
      end
    end
  end

  // keep ready low for the cycle between done and the result post
  assign out_ch.valid = out_v_r;
  assign out_ch.found = out_found_r;
  assign out_ch.elem_index = out_idx_r;
endmodule

// ----- dv/mpl_if.sv -----
`timescale 1ns / 1ps

// ----- dv/tb_mesh_point_locator_top.sv -----
`timescale 1ns / 1ps

module tb_mesh_point_locator_top;
  import mpl_pkg::*;

  localparam int NSLOT = 4096;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam longint TOL_MIN = -(64'sd1 <<< 51);
  localparam longint TOL_MAX = (64'sd1 <<< 51) - 1;
  localparam logic [3:0] ADDR_TOL = {REG_TOL, 3'b000};
  localparam logic [3:0] ADDR_CNT = {REG_CNT, 3'b000};
  localparam int M = -8388608;
  localparam int P = 8388607;

  // one input word
  typedef struct {
    req_t req;
    logic [IDX_W-1:0] entry;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [IDX_W-1:0] na, nb, nc, nd;
    logic quad;
  } mesh_word_t;

  // directed row: optional register setup, then one word
  typedef struct {
    mesh_word_t w;
    bit chk;
    bit exp_found;
    logic [IDX_W-1:0] exp_idx;
    bit cfg;
    longint tol;
    int cnt;
  } dir_row_t;

  typedef struct {
    bit found;
    logic [IDX_W-1:0] idx;
  } hit_t;

  typedef struct {
    logic [IDX_W-1:0] c [4];
    bit quad;
  } elem_t;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0] cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  mpl_in_if in_ch ();
  mpl_out_if out_ch ();

  mesh_point_locator_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // mirror of the mesh and the registers
  logic signed [COORD_W-1:0] node_x [NSLOT];
  logic signed [COORD_W-1:0] node_y [NSLOT];
  elem_t elems [NSLOT];
  bit node_set [NSLOT];
  bit elem_set [NSLOT];
  int node_list [$];
  longint tol_q;
  int cnt_q;

  hit_t hit_q [$];
  int errors;
  int idle_cycles;
  bit no_gaps;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // first element that is not rejected by any edge, scanning in order
  function automatic hit_t locate_point(logic signed [COORD_W-1:0] px,
                                        logic signed [COORD_W-1:0] py);
    hit_t h;
    int lim;
    int n;
    int j;
    bit inside_all;
    longint ax, ay, bx, by, v;
    h.found = 1'b0;
    h.idx = '0;
    lim = (cnt_q > NSLOT) ? NSLOT : cnt_q;
    for (int e = 0; e < lim; e++) begin
      n = elems[e].quad ? 4 : 3;
      inside_all = 1'b1;
      for (int i = 0; i < n; i++) begin
        j = (i + 1 == n) ? 0 : i + 1;
        ax = longint'(node_x[elems[e].c[i]]);
        ay = longint'(node_y[elems[e].c[i]]);
        bx = longint'(node_x[elems[e].c[j]]);
        by = longint'(node_y[elems[e].c[j]]);
        v = (longint'(px) - ax) * (ay - by) + (longint'(py) - ay) * (bx - ax);
        if (v < tol_q) inside_all = 1'b0;
      end
      if (inside_all) begin
        h.found = 1'b1;
        h.idx = e[IDX_W-1:0];
        break;
      end
    end
    return h;
  endfunction

  // apply one accepted word to the mirror, return the predicted result
  function automatic hit_t mesh_update(mesh_word_t w);
    hit_t h;
    h.found = 1'b0;
    h.idx = '0;
    case (w.req)
      REQ_NODE: begin
        node_x[w.entry] = w.x;
        node_y[w.entry] = w.y;
        if (!node_set[w.entry]) node_list.push_back(w.entry);
        node_set[w.entry] = 1'b1;
      end
      REQ_ELEM: begin
        elems[w.entry].c[0] = w.na;
        elems[w.entry].c[1] = w.nb;
        elems[w.entry].c[2] = w.nc;
        elems[w.entry].c[3] = w.nd;
        elems[w.entry].quad = w.quad;
        elem_set[w.entry] = 1'b1;
      end
      REQ_LOCATE: h = locate_point(w.x, w.y);
      default: ;
    endcase
    return h;
  endfunction

  function automatic mesh_word_t word_of(req_t r, int entry, int x, int y,
                                         int a, int b, int c, int d, bit q);
    mesh_word_t w;
    w.req = r;
    w.entry = entry[IDX_W-1:0];
    w.x = x[COORD_W-1:0];
    w.y = y[COORD_W-1:0];
    w.na = a[IDX_W-1:0];
    w.nb = b[IDX_W-1:0];
    w.nc = c[IDX_W-1:0];
    w.nd = d[IDX_W-1:0];
    w.quad = q;
    return w;
  endfunction

  function automatic int elem_prefix();
    int k;
    k = 0;
    while (k < NSLOT && elem_set[k]) k++;
    return k;
  endfunction

  function automatic int pick_node();
    return node_list[$urandom_range(0, node_list.size() - 1)];
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(0, 1)) return $urandom_range(0, 32767) - 16384;
    return int'($signed(24'($urandom())));
  endfunction

  function automatic mesh_word_t random_word();
    mesh_word_t w;
    int sel, pre, e, n, lim;
    longint sx, sy;
    w = word_of(REQ_LOCATE, $urandom(), rand_coord(), rand_coord(),
                $urandom(), $urandom(), $urandom(), $urandom(), $urandom_range(0, 1));
    sel = $urandom_range(0, 99);
    pre = elem_prefix();
    lim = (cnt_q > NSLOT) ? NSLOT : cnt_q;
    if (lim > pre) lim = pre;
    if (sel < 25) begin
      w.req = REQ_NODE;
    end else if (sel < 50) begin
      w.req = REQ_ELEM;
      w.na = IDX_W'(pick_node());
      w.nb = IDX_W'(pick_node());
      w.nc = IDX_W'(pick_node());
      if (w.quad) w.nd = IDX_W'(pick_node());
      if (pre < NSLOT && $urandom_range(0, 9) < 7) w.entry = IDX_W'(pre);
    end else if (sel < 95) begin
      // aim at the center of a scanned element to get hits
      if (lim > 0 && $urandom_range(0, 1)) begin
        e = $urandom_range(0, lim - 1);
        n = elems[e].quad ? 4 : 3;
        sx = 0;
        sy = 0;
        for (int i = 0; i < n; i++) begin
          sx += longint'(node_x[elems[e].c[i]]);
          sy += longint'(node_y[elems[e].c[i]]);
        end
        w.x = 24'(sx / n);
        w.y = 24'(sy / n);
      end
    end else begin
      w.req = REQ_NONE;
    end
    return w;
  endfunction

  // register write: setup then access
  task automatic reg_write(logic [3:0] addr, logic [63:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // only while the block is idle
  task automatic set_regs(longint tol, int cnt);
    drain();
    reg_write(ADDR_TOL, 64'(tol));
    reg_write(ADDR_CNT, 64'(cnt));
    tol_q = tol;
    cnt_q = cnt & 16'h1fff;
  endtask

  // drive one word, wait for the handshake, queue the expected result
  task automatic send_word(mesh_word_t w, bit chk, bit ef, logic [IDX_W-1:0] ei);
    int gap;
    hit_t h;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= w.req;
    in_ch.entry_index <= w.entry;
    in_ch.x_coord <= w.x;
    in_ch.y_coord <= w.y;
    in_ch.node_a <= w.na;
    in_ch.node_b <= w.nb;
    in_ch.node_c <= w.nc;
    in_ch.node_d <= w.nd;
    in_ch.is_quad <= w.quad;
    do @(posedge clk); while (!in_ch.ready);
    h = mesh_update(w);
    if (chk) begin
      h.found = ef;
      h.idx = ei;
    end
    hit_q.push_back(h);
  endtask

  // result side: random stalls, compare with oldest expectation
  initial begin
    int stall;
    hit_t e;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (hit_q.size() == 0) begin
        $display("%0t: unexpected word found=%0d elem_index=%0d", $realtime,
                 out_ch.found, out_ch.elem_index);
        errors++;
      end else begin
        e = hit_q.pop_front();
        if (out_ch.found !== e.found) begin
          $display("%0t: found expected %0d actual %0d", $realtime, e.found,
                   out_ch.found);
          errors++;
        end
        if (out_ch.elem_index !== e.idx) begin
          $display("%0t: elem_index expected %0d actual %0d", $realtime, e.idx,
                   out_ch.elem_index);
          errors++;
        end
      end
    end
  end

  dir_row_t dir_rows [$];

  initial begin
    dir_row_t r;
    int pre;
    errors = 0;
    idle_cycles = 0;
    no_gaps = 1'b0;
    tol_q = 0;
    cnt_q = 0;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_NONE;
    in_ch.entry_index = '0;
    in_ch.x_coord = '0;
    in_ch.y_coord = '0;
    in_ch.node_a = '0;
    in_ch.node_b = '0;
    in_ch.node_c = '0;
    in_ch.node_d = '0;
    in_ch.is_quad = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      node_set[i] = 1'b0;
      elem_set[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; chk rows carry a result that is obvious by inspection
    r.chk = 1;
    r.exp_found = 0;
    r.exp_idx = '0;
    r.cfg = 0;
    r.tol = 0;
    r.cnt = 0;
    r.w = word_of(REQ_LOCATE, 0, 0, 0, 0, 0, 0, 0, 0);  // empty scan after reset
    dir_rows.push_back(r);
    r.w = word_of(REQ_NONE, 4095, -1, -1, 4095, 4095, 4095, 4095, 1);  // idle selector
    dir_rows.push_back(r);
    // node loads, some at coordinate extremes, give an all-zero word
    r.w = word_of(REQ_NODE, 0, M, M, 0, 0, 0, 0, 0);        dir_rows.push_back(r);
    r.w = word_of(REQ_NODE, 1, P, M, 0, 0, 0, 0, 0);        dir_rows.push_back(r);
    r.w = word_of(REQ_NODE, 2, 0, P, 0, 0, 0, 0, 0);        dir_rows.push_back(r);
    r.w = word_of(REQ_NODE, 3, -4096, -4096, 0, 0, 0, 0, 0); dir_rows.push_back(r);
    r.w = word_of(REQ_NODE, 4, 4096, -4096, 0, 0, 0, 0, 0);  dir_rows.push_back(r);
    r.w = word_of(REQ_NODE, 5, 4096, 4096, 0, 0, 0, 0, 0);   dir_rows.push_back(r);
    r.w = word_of(REQ_NODE, 6, -4096, 4096, 0, 0, 0, 0, 0);  dir_rows.push_back(r);
    r.w = word_of(REQ_NODE, 4095, P, P, 0, 0, 0, 0, 0);      dir_rows.push_back(r);
    // element loads: small triangle, square quad, big ccw, big cw, mixed quad
    r.w = word_of(REQ_ELEM, 0, 0, 0, 3, 4, 5, 4095, 0);      dir_rows.push_back(r);
    r.w = word_of(REQ_ELEM, 1, 0, 0, 3, 4, 5, 6, 1);         dir_rows.push_back(r);
    r.w = word_of(REQ_ELEM, 2, 0, 0, 0, 1, 2, 0, 0);         dir_rows.push_back(r);
    r.w = word_of(REQ_ELEM, 3, 0, 0, 2, 1, 0, 0, 0);         dir_rows.push_back(r);
    r.w = word_of(REQ_ELEM, 4, 0, 0, 4095, 6, 3, 5, 1);      dir_rows.push_back(r);
    // lowest tolerance lets element 0 pass at once
    r.cfg = 1; r.tol = TOL_MIN; r.cnt = 5;
    r.w = word_of(REQ_LOCATE, 0, M, P, 0, 0, 0, 0, 0);
    r.exp_found = 1;
    dir_rows.push_back(r);
    // highest tolerance rejects every element
    r.tol = TOL_MAX; r.exp_found = 0;
    r.w = word_of(REQ_LOCATE, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_rows.push_back(r);
    // remaining rows go through the mirror
    r.chk = 0; r.tol = 0;
    r.w = word_of(REQ_LOCATE, 0, 0, 0, 0, 0, 0, 0, 0);       dir_rows.push_back(r);
    r.cfg = 0;
    r.w = word_of(REQ_LOCATE, 0, -4096, 0, 0, 0, 0, 0, 0);   dir_rows.push_back(r);
    r.w = word_of(REQ_LOCATE, 0, 2048, -2048, 0, 0, 0, 0, 0); dir_rows.push_back(r);
    r.w = word_of(REQ_LOCATE, 0, M, M, 0, 0, 0, 0, 0);       dir_rows.push_back(r);
    r.w = word_of(REQ_LOCATE, 0, P, P, 0, 0, 0, 0, 0);       dir_rows.push_back(r);
    r.w = word_of(REQ_LOCATE, 0, 1000000, 10, 0, 0, 0, 0, 0); dir_rows.push_back(r);
    // point on an edge: passes at tolerance 0, fails at 1
    r.cfg = 1; r.tol = 1; r.cnt = 2;
    r.w = word_of(REQ_LOCATE, 0, -4096, 0, 0, 0, 0, 0, 0);   dir_rows.push_back(r);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg) set_regs(dir_rows[i].tol, dir_rows[i].cnt);
      send_word(dir_rows[i].w, dir_rows[i].chk, dir_rows[i].exp_found,
                dir_rows[i].exp_idx);
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      longint t;
      int c;
      pre = elem_prefix();
      case (ph)
        0: t = 0;
        1: t = $urandom_range(0, 1 << 20);
        2: t = -longint'($urandom_range(0, 1 << 20));
        3: t = TOL_MIN;
        4: t = TOL_MAX;
        default: t = longint'($urandom_range(0, 1 << 24)) - (1 << 23);
      endcase
      c = (ph == 2) ? 0 : $urandom_range(1, (pre < 40) ? pre : 40);
      set_regs(t, c);
      no_gaps = (ph == 1);
      for (int k = 0; k < 19; k++) begin
        send_word(random_word(), 0, 0, '0);
        // at least once let the results catch up before going on
        if (ph == 0 && k == 9) drain();
      end
    end

    no_gaps = 1'b0;
    // counts beyond the store depth clamp to it; element 0 passes first
    set_regs(TOL_MIN, 8191);
    for (int k = 0; k < 3; k++) send_word(random_word(), 0, 0, '0);
    set_regs(TOL_MIN, 4096);
    send_word(word_of(REQ_LOCATE, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, '0);

    in_ch.valid <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
